// File: rtl/core/srbk_pkg.sv
// ----------------------------------------------------------------------------
// srbk_pkg: shared types for the record sorter
// Beat payloads, cell entry and cell control for the insertion chain.
// ----------------------------------------------------------------------------
package srbk_pkg;

    localparam int MAX_RECORDS_DEF = 64;

    typedef struct packed {
        logic signed [31:0] sort_key;
        logic        [15:0] record_tag;
        logic               final_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic        [15:0] sorted_tag;
        logic               run_end;
    } t_out_beat;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic        [15:0] tag;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

// File: rtl/core/srbk_cell.sv
// ----------------------------------------------------------------------------
// srbk_cell: one slot of the insertion chain
// Holds one record; takes the new record, its left neighbour's record on
// insertion, or its right neighbour's record while the chain drains.
// ----------------------------------------------------------------------------
module srbk_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srbk_pkg::t_cell_ctl i_ctl,
    input  srbk_pkg::t_entry    i_new,
    input  srbk_pkg::t_entry    i_left,
    input  logic                i_left_ins,
    input  srbk_pkg::t_entry    i_right,
    output srbk_pkg::t_entry    o_entry,
    output logic                o_ins
);

    logic               r_valid;
    logic signed [31:0] r_key;
    logic        [15:0] r_tag;
    srbk_pkg::t_entry   n_entry;
    logic               n_load;

    assign o_ins = !r_valid || ($signed(r_key) > $signed(i_new.key));

    always_comb begin
        n_load  = 1'b0;
        n_entry = i_new;
        if (i_ctl.shift) begin
            n_load  = 1'b1;
            n_entry = i_right;
        end else if (i_ctl.insert && o_ins) begin
            n_load  = 1'b1;
            n_entry = i_left_ins ? i_left : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= n_entry.valid;
        end
        if (n_load) begin
            r_key <= n_entry.key;
            r_tag <= n_entry.tag;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, tag: r_tag};

endmodule

// File: rtl/core/sort_records_by_key.sv
// Latency: a record enters the chain in the cycle its beat is accepted, unless
// the chain is full; the first result beat is offered in the cycle after the
// final record's beat. Throughput: one record per cycle while loading, then
// one result per cycle while draining unless i_stall is high; input stalled throughout.
// Reset: the chain empties at once; stored keys and tags are not cleared.
// ----------------------------------------------------------------------------
// sort_records_by_key: stable ascending record sorter
// Row of insertion cells kept in key order, drained from the head.
// ----------------------------------------------------------------------------
module sort_records_by_key #(
    parameter int MAX_RECORDS = srbk_pkg::MAX_RECORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  srbk_pkg::t_in_beat  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output srbk_pkg::t_out_beat o_data
);

    srbk_pkg::t_entry    w_entry [MAX_RECORDS];
    logic                w_ins   [MAX_RECORDS];
    srbk_pkg::t_entry    w_new;
    srbk_pkg::t_cell_ctl w_ctl;
    logic                r_drain;
    logic                w_full;
    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_run_end;

    assign w_full    = w_entry[MAX_RECORDS-1].valid;
    assign w_in_acc  = i_valid && !r_drain;
    assign w_out_acc = o_valid && !i_stall;
    assign w_run_end = !w_entry[1].valid;

    assign w_new        = '{valid: 1'b1, key: i_data.sort_key, tag: i_data.record_tag};
    assign w_ctl.insert = w_in_acc && !w_full;
    assign w_ctl.shift  = w_out_acc;

    genvar g;
    generate
        for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
            srbk_pkg::t_entry w_left;
            srbk_pkg::t_entry w_right;
            logic             w_left_ins;
            if (g == 0) begin : g_head
                assign w_left     = '0;
                assign w_left_ins = 1'b0;
            end else begin : g_body
                assign w_left     = w_entry[g-1];
                assign w_left_ins = w_ins[g-1];
            end
            if (g == MAX_RECORDS - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_link
                assign w_right = w_entry[g+1];
            end
            srbk_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_new      (w_new),
                .i_left     (w_left),
                .i_left_ins (w_left_ins),
                .i_right    (w_right),
                .o_entry    (w_entry[g]),
                .o_ins      (w_ins[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
        end else if (w_in_acc && i_data.final_item) begin
            r_drain <= 1'b1;
        end else if (w_out_acc && w_run_end) begin
            r_drain <= 1'b0;
        end
    end

    assign o_stall           = r_drain;
    assign o_valid           = r_drain && w_entry[0].valid;
    assign o_data.sorted_key = w_entry[0].key;
    assign o_data.sorted_tag = w_entry[0].tag;
    assign o_data.run_end    = w_run_end;

endmodule
